/* rtl/sdpv_pkg.sv */
// Package for the stereo distance pan volume block.
// Holds widths, constants and the word types handed along the divider chain.
// No dependencies.
`default_nettype none

package sdpv_pkg;

  // field widths
  localparam int unsigned DIST_W  = 24;
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned VOL_W   = 14;

  // divider: dividend is distance shifted up by the fraction bits
  localparam int unsigned FRAC_SHIFT = 8;
  localparam int unsigned NUM_W      = DIST_W + FRAC_SHIFT;
  localparam int unsigned DIV_STEPS  = NUM_W;

  // only the low bits of the scale reach the 16-bit attenuation
  localparam int unsigned SCALE_W = 24;
  localparam int unsigned ATT_W   = 16;
  localparam int unsigned WGT_W   = 8;
  localparam int unsigned MUL_W   = ATT_W + WGT_W + 1;
  localparam int unsigned PAN_SHIFT = 7;

  localparam logic [VOL_W-1:0]   VOL_MAX  = 14'h3fff;
  localparam logic [ANGLE_W-1:0] ANGLE_LO = 8'd64;
  localparam logic [ANGLE_W-1:0] ANGLE_HI = 8'd192;
  localparam logic [ANGLE_W-1:0] PAN_MID  = 8'd128;

  // word travelling through the divider cells
  typedef struct packed {
    logic [DIST_W-1:0]  rem;
    logic [NUM_W-1:0]   num;      // remaining dividend bits on top, quotient bits below
    logic [DIST_W-1:0]  divisor;
    logic [ANGLE_W-1:0] angle;
    logic [VOL_W-1:0]   base_l;
    logic [VOL_W-1:0]   base_r;
    logic               skip;
  } div_word_t;

endpackage

`default_nettype wire

/* rtl/sdpv_div_cell.sv */
// One restoring division step with its own register and handshake.
// Depends on sdpv_pkg.
`default_nettype none

module sdpv_div_cell
  import sdpv_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire div_word_t word_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output div_word_t      word_o
);

  logic        valid_q;
  div_word_t   word_q, word_d;
  logic [DIST_W:0]   trial;
  logic [DIST_W+1:0] diff;
  logic              take;

  // shift in the next dividend bit, subtract where it fits
  always_comb begin
    trial  = {word_i.rem, word_i.num[NUM_W-1]};
    diff   = {1'b0, trial} - {2'b00, word_i.divisor};
    take   = ~diff[DIST_W+1];
    word_d = word_i;
    word_d.rem = take ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
    word_d.num = {word_i.num[NUM_W-2:0], take};
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

/* rtl/sdpv_pan.sv */
// Attenuation, pan weighting, clamp and mono mix: three handshaked stages.
// Depends on sdpv_pkg.
`default_nettype none

module sdpv_pan
  import sdpv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire div_word_t   word_i,
  input  wire logic        mono_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [VOL_W-1:0] volume_left_o,
  output logic [VOL_W-1:0] volume_right_o,
  output logic             skipped_o
);

  // stage A: scale times base, pan weights
  logic                a_valid_q, a_ready;
  logic [SCALE_W-1:0]  a_prod_l_q, a_prod_r_q;
  logic [VOL_W-1:0]    a_base_l_q, a_base_r_q;
  logic [WGT_W-1:0]    a_wl_q, a_wr_q, a_wl_d, a_wr_d;
  logic                a_skip_q;
  logic [SCALE_W+VOL_W-1:0] full_l, full_r;
  logic [SCALE_W-1:0]  scale;

  // stage B: attenuated value times weight
  logic                b_valid_q, b_ready;
  logic signed [MUL_W-1:0] b_mul_l_q, b_mul_r_q, b_mul_l_d, b_mul_r_d;
  logic [VOL_W-1:0]    b_base_l_q, b_base_r_q;
  logic                b_skip_q;
  logic [ATT_W-1:0]    att_l, att_r;

  // stage C: clamp, mono mix, skip select
  logic                c_valid_q;
  logic [VOL_W-1:0]    c_left_q, c_right_q, c_left_d, c_right_d;
  logic                c_skip_q;
  logic [VOL_W-1:0]    cl_l, cl_r;
  logic [VOL_W:0]      mono_sum;

  function automatic logic [VOL_W-1:0] clamp_vol(input logic signed [MUL_W-1:0] m);
    logic [ATT_W-1:0] r;
    r = m[PAN_SHIFT+ATT_W-1:PAN_SHIFT];
    if (r[ATT_W-1]) begin
      return '0;
    end else if (|r[ATT_W-2:VOL_W]) begin
      return VOL_MAX;
    end
    return r[VOL_W-1:0];
  endfunction

  assign ready_o = ~a_valid_q | a_ready;
  assign a_ready = ~b_valid_q | b_ready;
  assign b_ready = ~c_valid_q | ready_i;

  // stage A logic
  assign scale  = word_i.num[SCALE_W-1:0];
  assign full_l = scale * word_i.base_l;
  assign full_r = scale * word_i.base_r;

  always_comb begin
    if (word_i.angle >= ANGLE_LO && word_i.angle < ANGLE_HI) begin
      a_wl_d = 8'd0 - word_i.angle;
      a_wr_d = word_i.angle;
    end else begin
      a_wl_d = word_i.angle + PAN_MID;
      a_wr_d = PAN_MID - word_i.angle;
    end
  end

  // stage B logic: wraps to 16 bits as the attenuation may go negative
  assign att_l     = ATT_W'(a_base_l_q) - a_prod_l_q[SCALE_W-1:FRAC_SHIFT];
  assign att_r     = ATT_W'(a_base_r_q) - a_prod_r_q[SCALE_W-1:FRAC_SHIFT];
  assign b_mul_l_d = $signed({1'b0, a_wl_q}) * $signed(att_l);
  assign b_mul_r_d = $signed({1'b0, a_wr_q}) * $signed(att_r);

  // stage C logic
  assign cl_l     = clamp_vol(b_mul_l_q);
  assign cl_r     = clamp_vol(b_mul_r_q);
  assign mono_sum = {1'b0, cl_l} + {1'b0, cl_r};

  always_comb begin
    if (b_skip_q) begin
      c_left_d  = b_base_l_q;
      c_right_d = b_base_r_q;
    end else if (mono_i) begin
      c_left_d  = mono_sum[VOL_W:1];
      c_right_d = mono_sum[VOL_W:1];
    end else begin
      c_left_d  = cl_l;
      c_right_d = cl_r;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (ready_o) a_valid_q <= valid_i;
      if (a_ready) b_valid_q <= a_valid_q;
      if (b_ready) c_valid_q <= b_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      a_prod_l_q <= full_l[SCALE_W-1:0];
      a_prod_r_q <= full_r[SCALE_W-1:0];
      a_base_l_q <= word_i.base_l;
      a_base_r_q <= word_i.base_r;
      a_wl_q     <= a_wl_d;
      a_wr_q     <= a_wr_d;
      a_skip_q   <= word_i.skip;
    end
    if (a_valid_q && a_ready) begin
      b_mul_l_q  <= b_mul_l_d;
      b_mul_r_q  <= b_mul_r_d;
      b_base_l_q <= a_base_l_q;
      b_base_r_q <= a_base_r_q;
      b_skip_q   <= a_skip_q;
    end
    if (b_valid_q && b_ready) begin
      c_left_q  <= c_left_d;
      c_right_q <= c_right_d;
      c_skip_q  <= b_skip_q;
    end
  end

  assign valid_o        = c_valid_q;
  assign volume_left_o  = c_left_q;
  assign volume_right_o = c_right_q;
  assign skipped_o      = c_skip_q;

endmodule

`default_nettype wire

/* rtl/stereo_distance_pan_volume.sv */
// Pipeline: 32 divider cells, then 3 pan stages, each a registered handshake stage.
// Throughput: one word per cycle while the output accepts; each divider cell does one compare-subtract per word.
// A stall reaches back only through full stages, so empty stages keep filling while a result waits.
// Reset: asynchronous active low; clears all valid flags and mono mode.
// Depends on sdpv_pkg, sdpv_div_cell and sdpv_pan.
`default_nettype none

module stereo_distance_pan_volume
  import sdpv_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_mono_mode_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [DIST_W-1:0]  distance_i,
  input  wire logic [ANGLE_W-1:0] direction_angle_i,
  input  wire logic [DIST_W-1:0]  max_distance_i,
  input  wire logic [VOL_W-1:0]   base_left_i,
  input  wire logic [VOL_W-1:0]   base_right_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [VOL_W-1:0]        volume_left_o,
  output logic [VOL_W-1:0]        volume_right_o,
  output logic                    skipped_o
);

  logic      mono_q;
  div_word_t chain_word [DIV_STEPS+1];
  logic      chain_valid [DIV_STEPS+1];
  logic      chain_ready [DIV_STEPS+1];

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mono_q <= cfg_mono_mode_i;
    end
  end

  // head of the divider chain
  always_comb begin
    chain_word[0].rem     = '0;
    chain_word[0].num     = {distance_i, {FRAC_SHIFT{1'b0}}};
    chain_word[0].divisor = max_distance_i;
    chain_word[0].angle   = direction_angle_i;
    chain_word[0].base_l  = base_left_i;
    chain_word[0].base_r  = base_right_i;
    chain_word[0].skip    = (max_distance_i == '0);
  end

  assign chain_valid[0] = in_valid_i;
  assign in_ready_o     = chain_ready[0];

  // row of division cells, one quotient bit each
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    sdpv_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .word_i  (chain_word[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .word_o  (chain_word[k+1])
    );
  end

  sdpv_pan u_pan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (chain_valid[DIV_STEPS]),
    .ready_o        (chain_ready[DIV_STEPS]),
    .word_i         (chain_word[DIV_STEPS]),
    .mono_i         (mono_q),
    .valid_o        (out_valid_o),
    .ready_i        (out_ready_i),
    .volume_left_o  (volume_left_o),
    .volume_right_o (volume_right_o),
    .skipped_o      (skipped_o)
  );

endmodule

`default_nettype wire

/* rtl/sdpv_checker.sv */
// Port-level checks for stereo_distance_pan_volume, attached by bind.
// Depends on sdpv_pkg.
`default_nettype none

module sdpv_checker
  import sdpv_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic               cfg_mono_mode_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [VOL_W-1:0]   volume_left_o,
  input wire logic [VOL_W-1:0]   volume_right_o,
  input wire logic               skipped_o
);

  logic mono_q;

  // shadow of the mono register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mono_q <= cfg_mono_mode_i;
    end
  end

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(volume_left_o)
      && $stable(volume_right_o) && $stable(skipped_o))
    else $error("result word changed while stalled");

  // config is never back-pressured
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

  // an output side that can move lets the input side move
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled with free output");

  // mono mix gives equal channels unless passed through
  a_mono_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mono_q && !skipped_o |-> volume_left_o == volume_right_o)
    else $error("mono channels differ");

endmodule

bind stereo_distance_pan_volume sdpv_checker u_sdpv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o),
  .cfg_mono_mode_i (cfg_mono_mode_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .volume_left_o   (volume_left_o),
  .volume_right_o  (volume_right_o),
  .skipped_o       (skipped_o)
);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for stereo_distance_pan_volume.
// Drives voice words from a queue, predicts each volume word locally and checks every output word.
// Depends on sdpv_pkg and the stereo_distance_pan_volume RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdpv_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 40;    // a little over the pipeline depth
  localparam int unsigned IDLE_PCT     = 24;
  localparam int unsigned LONG_HOLD    = 250;   // output stall, fills the pipeline
  localparam int unsigned HOLD_AT_WORD = 300;
  localparam logic        MONO_OFF     = 1'b0;
  localparam logic        MONO_ON      = 1'b1;

  // one voice setup as offered on the input channel
  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  max_distance;
    logic [VOL_W-1:0]   base_l;
    logic [VOL_W-1:0]   base_r;
  } voice_t;

  // one volume word as produced on the output channel
  typedef struct packed {
    logic [VOL_W-1:0] vol_l;
    logic [VOL_W-1:0] vol_r;
    logic             skipped;
  } volume_t;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               cfg_valid_i       = 1'b0;
  logic               cfg_mono_mode_i   = 1'b0;
  logic               in_valid_i        = 1'b0;
  logic [DIST_W-1:0]  distance_i        = '0;
  logic [ANGLE_W-1:0] direction_angle_i = '0;
  logic [DIST_W-1:0]  max_distance_i    = '0;
  logic [VOL_W-1:0]   base_left_i       = '0;
  logic [VOL_W-1:0]   base_right_i      = '0;
  logic               out_ready_i       = 1'b0;
  logic               cfg_ready_o;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [VOL_W-1:0]   volume_left_o;
  logic [VOL_W-1:0]   volume_right_o;
  logic               skipped_o;

  voice_t      pending_voices[$];
  volume_t     expected_volumes[$];
  voice_t      offered;
  volume_t     want;
  logic        mono_setting = 1'b0;
  logic        steady       = 1'b0;   // no idling on either side while set
  int unsigned words_out    = 0;
  int unsigned hold_left    = 0;
  int unsigned error_count  = 0;

  stereo_distance_pan_volume uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_mono_mode_i   (cfg_mono_mode_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .distance_i        (distance_i),
    .direction_angle_i (direction_angle_i),
    .max_distance_i    (max_distance_i),
    .base_left_i       (base_left_i),
    .base_right_i      (base_right_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .volume_left_o     (volume_left_o),
    .volume_right_o    (volume_right_o),
    .skipped_o         (skipped_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // attenuate, pan and clamp one channel; arithmetic wraps at 32 bits, attenuation and panned value at 16 bits
  function automatic logic [VOL_W-1:0] pan_channel(input logic [VOL_W-1:0] base,
                                                    input logic [31:0] scale,
                                                    input logic [WGT_W-1:0] weight);
    logic [31:0]        atten;
    logic signed [15:0] att16;
    logic signed [31:0] product;
    logic signed [31:0] shifted;
    logic signed [15:0] panned;
    atten   = {18'd0, base} - ((scale * {18'd0, base}) >> FRAC_SHIFT);
    att16   = atten[15:0];
    product = $signed({1'b0, weight}) * att16;
    shifted = product >>> PAN_SHIFT;
    panned  = shifted[15:0];
    if (int'(panned) < 0) begin
      return '0;
    end
    if (int'(panned) > int'(VOL_MAX)) begin
      return VOL_MAX;
    end
    return panned[VOL_W-1:0];
  endfunction

  // expected volume word for one voice under the given mono setting
  function automatic volume_t predict_volumes(input voice_t v, input logic mono);
    volume_t          res;
    logic [31:0]      scale;
    logic [WGT_W-1:0] w_l;
    logic [WGT_W-1:0] w_r;
    logic [VOL_W:0]   sum;
    // zero fade-out distance: bases pass straight through, mono ignored
    if (v.max_distance == '0) begin
      res.vol_l   = v.base_l;
      res.vol_r   = v.base_r;
      res.skipped = 1'b1;
      return res;
    end
    if (v.angle >= ANGLE_LO && v.angle < ANGLE_HI) begin
      w_l = ~v.angle + 8'd1;
      w_r = v.angle;
    end else begin
      w_l = v.angle + PAN_MID;
      w_r = PAN_MID - v.angle;
    end
    scale       = {v.distance, 8'd0} / {8'd0, v.max_distance};
    res.vol_l   = pan_channel(v.base_l, scale, w_l);
    res.vol_r   = pan_channel(v.base_r, scale, w_r);
    res.skipped = 1'b0;
    if (mono) begin
      sum       = {1'b0, res.vol_l} + {1'b0, res.vol_r};
      res.vol_l = sum[VOL_W:1];
      res.vol_r = sum[VOL_W:1];
    end
    return res;
  endfunction

  task automatic check_field(input string what, input int want_v, input int got_v);
    if (want_v != got_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
    end
  endtask

  task automatic add_voice(input logic [DIST_W-1:0] d, input logic [ANGLE_W-1:0] a,
                           input logic [DIST_W-1:0] m, input logic [VOL_W-1:0] bl,
                           input logic [VOL_W-1:0] br);
    voice_t v;
    v.distance     = d;
    v.angle        = a;
    v.max_distance = m;
    v.base_l       = bl;
    v.base_r       = br;
    pending_voices.push_back(v);
  endtask

  // random voices: mostly sources inside the fade-out distance, some beyond, a few skipped
  task automatic add_random_voices(input int unsigned count);
    int unsigned       kind;
    logic [DIST_W-1:0] d;
    logic [DIST_W-1:0] m;
    logic [VOL_W-1:0]  bl;
    logic [VOL_W-1:0]  br;
    for (int unsigned i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        m = '0;
        d = DIST_W'($urandom_range(0, 24'hffffff));
      end else if (kind < 20) begin
        m = DIST_W'($urandom_range(1, 24'hffffff));
        d = DIST_W'($urandom_range(0, 24'hffffff));
      end else if (kind < 35) begin
        m = DIST_W'($urandom_range(1, 1023));
        d = DIST_W'($urandom_range(0, m));
      end else begin
        m = DIST_W'($urandom_range(1, 24'hffffff));
        d = DIST_W'($urandom_range(0, m));
      end
      bl = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? VOL_MAX : '0)
                                       : VOL_W'($urandom_range(0, VOL_MAX));
      br = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? VOL_MAX : '0)
                                       : VOL_W'($urandom_range(0, VOL_MAX));
      add_voice(d, ANGLE_W'($urandom_range(0, 255)), m, bl, br);
    end
  endtask

  // configuration word, only issued while the block is empty
  task automatic write_mono(input logic mono);
    @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_mono_mode_i <= mono;
    do @(posedge clk_i); while (!cfg_ready_o);
    mono_setting = mono;
    cfg_valid_i <= 1'b0;
  endtask

  // sender holds off until every expected word has come back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_voices.size() != 0 || in_valid_i || expected_volumes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // input driver: predicts at acceptance, holds the word while stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_volumes.push_back(predict_volumes(offered, mono_setting));
      end
      if (in_valid_i && !in_ready_o) begin
        // word still waiting, keep it on the bus
      end else if (pending_voices.size() != 0 &&
                   (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        offered = pending_voices.pop_front();
        in_valid_i        <= 1'b1;
        distance_i        <= offered.distance;
        direction_angle_i <= offered.angle;
        max_distance_i    <= offered.max_distance;
        base_left_i       <= offered.base_l;
        base_right_i      <= offered.base_r;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output monitor: compares each word with the oldest prediction, drives ready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        words_out++;
        if (expected_volumes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected word, expected none, got left %0d right %0d skipped %0d",
                   $time, volume_left_o, volume_right_o, skipped_o);
        end else begin
          want = expected_volumes.pop_front();
          check_field("volume_left", want.vol_l, volume_left_o);
          check_field("volume_right", want.vol_r, volume_right_o);
          check_field("skipped", want.skipped, skipped_o);
        end
        // one long back-pressure stretch so the pipeline fills and stalls its input
        if (words_out == HOLD_AT_WORD) begin
          hold_left = LONG_HOLD;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // run limit, far above the slowest correct run
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // reset, then phases of stimulus with mono mode changed in between
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_mono(MONO_OFF);
    // directed: field extremes, skip, every pan region boundary, source beyond fade-out
    add_voice(24'h0,      8'd0,   24'h0,      14'h0,    14'h0);
    add_voice(24'hffffff, 8'd255, 24'h0,      14'h3fff, 14'h3fff);
    add_voice(24'h0,      8'd0,   24'hffffff, 14'h3fff, 14'h3fff);
    add_voice(24'hffffff, 8'd64,  24'hffffff, 14'h3fff, 14'h0);
    add_voice(24'h0,      8'd63,  24'h1,      14'h3fff, 14'h3fff);
    add_voice(24'h0,      8'd64,  24'h1,      14'h3fff, 14'h3fff);
    add_voice(24'h0,      8'd127, 24'h1,      14'h1234, 14'h2345);
    add_voice(24'h0,      8'd128, 24'h1,      14'h3fff, 14'h3fff);
    add_voice(24'h0,      8'd191, 24'h1,      14'h3fff, 14'h3fff);
    add_voice(24'h0,      8'd192, 24'h1,      14'h3fff, 14'h3fff);
    add_voice(24'h0,      8'd255, 24'h1,      14'h3fff, 14'h3fff);
    add_voice(24'hffffff, 8'd200, 24'h1,      14'h3fff, 14'h3fff);
    add_voice(24'd1000,   8'd30,  24'd10,     14'h2000, 14'h3fff);
    add_voice(24'h800000, 8'd100, 24'h400000, 14'h3fff, 14'h1);
    add_voice(24'h12345,  8'd90,  24'h800000, 14'h0,    14'h3fff);
    add_voice(24'h7fffff, 8'd160, 24'hffffff, 14'h2aaa, 14'h1555);
    add_voice(24'hfffffe, 8'd10,  24'hffffff, 14'h3fff, 14'h3fff);
    add_voice(24'd300,    8'd220, 24'd256,    14'h3fff, 14'h3fff);
    add_voice(24'h1,      8'd1,   24'h1,      14'h1,    14'h1);
    add_voice(24'h5fffff, 8'd190, 24'h2,      14'h3fff, 14'h3fff);
    wait_idle();

    write_mono(MONO_ON);
    add_random_voices(500);
    wait_idle();

    // a phase with no idling on either side
    steady <= 1'b1;
    write_mono(MONO_OFF);
    add_random_voices(450);
    wait_idle();
    steady <= 1'b0;

    write_mono(MONO_ON);
    add_random_voices(450);
    wait_idle();

    write_mono(MONO_OFF);
    add_random_voices(500);
    wait_idle();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sdpv_pkg.sv
rtl/sdpv_div_cell.sv
rtl/sdpv_pan.sv
rtl/stereo_distance_pan_volume.sv
rtl/sdpv_checker.sv
tb/tb.sv
